// ----- hw/rtl/pfcr_pkg.sv -----
package pfcr_pkg;

    localparam int FONT_BYTES      = 512;
    localparam int MAX_GLYPH_WIDTH = 16;
    localparam int MAX_COLUMNS     = 1024;

    localparam int ADDR_W  = $clog2(FONT_BYTES);
    localparam int COLS_W  = $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int COUNT_W = 10;
    localparam int CODE_W  = 6;
    localparam int COLOR_W = 3;
    localparam int LIMIT_W = 7;
    localparam int BYTE_W  = 8;
    localparam int FADDR_W = 9;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] INDEX_CAP =
        (MAX_COLUMNS > 1024) ? COUNT_W'(1023) : COUNT_W'(MAX_COLUMNS - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_COLS,
        ST_GAP
    } pfcr_state_t;

    typedef struct packed {
        logic write_font;
        logic load_char;
        logic walk_step;
        logic start_cols;
        logic emit_col;
        logic emit_gap;
    } pfcr_cmd_t;

    typedef struct packed {
        logic remain_zero;
        logic width_zero;
        logic cols_last;
        logic out_free;
    } pfcr_status_t;

endpackage

// ----- hw/rtl/pfcr_ctrl.sv -----
module pfcr_ctrl
    import pfcr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_op,
    output logic         s_tready,
    input  pfcr_status_t status,
    output pfcr_cmd_t    cmd
);

    pfcr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_op == OP_RENDER) begin
                        cmd.load_char = 1'b1;
                        state_next    = ST_WALK;
                    end else begin
                        cmd.write_font = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                // hop over one glyph per cycle until the wanted one is reached
                if (!status.remain_zero) begin
                    cmd.walk_step = 1'b1;
                end else if (status.width_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.start_cols = 1'b1;
                    state_next     = ST_COLS;
                end
            end
            ST_COLS: begin
                if (status.out_free) begin
                    cmd.emit_col = 1'b1;
                    if (status.cols_last) begin
                        state_next = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                if (status.out_free) begin
                    cmd.emit_gap = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pfcr_dpath.sv -----
module pfcr_dpath
    import pfcr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic [FADDR_W-1:0] font_addr,
    input  logic [BYTE_W-1:0]  font_data,
    input  logic [CODE_W-1:0]  char_code,
    input  logic [COLOR_W-1:0] char_color,
    input  logic               first_of_message,
    input  pfcr_cmd_t          cmd,
    output pfcr_status_t       status,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic               m_tlast,
    output logic [BYTE_W-1:0]  column_bits,
    output logic [COLOR_W-1:0] column_color,
    output logic [COUNT_W-1:0] column_index
);

    logic [BYTE_W-1:0]  font_mem [FONT_BYTES];
    logic [BYTE_W-1:0]  rdata_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [CODE_W-1:0]  remain_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               out_valid_reg;
    logic               out_last_reg;
    logic [BYTE_W-1:0]  out_bits_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [COUNT_W-1:0] out_index_reg;

    logic [CODE_W-1:0]  glyph;
    logic [COLS_W-1:0]  shown;
    logic [COUNT_W-1:0] count_inc;
    logic               out_free;

    assign glyph = (char_code != '0 && {1'b0, char_code} < limit_reg) ? char_code : '0;
    assign shown = (rdata_reg > BYTE_W'(MAX_GLYPH_WIDTH)) ? COLS_W'(MAX_GLYPH_WIDTH)
                                                         : COLS_W'(rdata_reg);
    assign count_inc = (count_reg < INDEX_CAP) ? count_reg + COUNT_W'(1) : INDEX_CAP;
    assign out_free  = !out_valid_reg || m_tready;

    // read address follows the next position so rdata_reg holds the byte at pos_reg
    always_comb begin
        pos_next = pos_reg;
        if (cmd.load_char) begin
            pos_next = '0;
        end else if (cmd.walk_step) begin
            pos_next = pos_reg + ADDR_W'(rdata_reg) + ADDR_W'(1);
        end else if (cmd.start_cols || cmd.emit_col) begin
            pos_next = pos_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_font) begin
            font_mem[ADDR_W'(font_addr)] <= font_data;
        end
        rdata_reg <= font_mem[pos_next];
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (cmd.load_char) begin
            remain_reg <= glyph;
            color_reg  <= char_color;
        end else if (cmd.walk_step) begin
            remain_reg <= remain_reg - CODE_W'(1);
        end
        if (cmd.start_cols) begin
            cols_reg <= shown;
        end else if (cmd.emit_col) begin
            cols_reg <= cols_reg - COLS_W'(1);
        end
        if (cmd.emit_col) begin
            out_bits_reg  <= rdata_reg;
            out_color_reg <= color_reg;
            out_index_reg <= count_reg;
            out_last_reg  <= 1'b0;
        end else if (cmd.emit_gap) begin
            out_bits_reg  <= '0;
            out_color_reg <= '0;
            out_index_reg <= count_reg;
            out_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.load_char && first_of_message) begin
                count_reg <= '0;
            end else if (cmd.emit_col || cmd.emit_gap) begin
                count_reg <= count_inc;
            end
            if (cmd.emit_col || cmd.emit_gap) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.remain_zero = (remain_reg == '0);
    assign status.width_zero  = (rdata_reg == '0);
    assign status.cols_last   = (cols_reg == COLS_W'(1));
    assign status.out_free    = out_free;

    assign m_tvalid     = out_valid_reg;
    assign m_tlast      = out_last_reg;
    assign column_bits  = out_bits_reg;
    assign column_color = out_color_reg;
    assign column_index = out_index_reg;

endmodule

// ----- hw/rtl/proportional_font_column_renderer.sv -----
// Proportional font column renderer.
// Input stream (s_): tuser = op, 0 loads one font byte, 1 renders one character.
// Font bytes hold glyphs back to back: a width byte, then that many columns.
// Output stream (m_): one beat per glyph column (at most 16) carrying the
// character colour, then a blank gap beat of colour 0 with tlast set.
// A glyph of width zero gives no beats at all.
// cfg_wr_en/cfg_wr_data write char_limit; write it only while the block idles.
// Font load beats are taken back to back. A character holds the input closed
// until its gap beat is loaded into the output register (for an empty glyph,
// until its width byte is read); the single read port of the font memory
// yields one byte per cycle, both for each width hop and for each column,
// the columns only while the output register is free.
// Reset clears char_limit to 64, the column index to 0 and output valid;
// font memory contents are kept and are undefined until loaded.
// If the receiver stalls, the current beat holds in the output register and
// the walk over columns pauses until it is taken.
module proportional_font_column_renderer
    import pfcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [8:0] font_addr, [16:9] font_data, [22:17] char_code,
    // [25:23] char_color, [26] first_of_message
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] column_bits, [10:8] column_color, [20:11] column_index
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    pfcr_cmd_t          cmd;
    pfcr_status_t       status;
    logic [BYTE_W-1:0]  column_bits;
    logic [COLOR_W-1:0] column_color;
    logic [COUNT_W-1:0] column_index;

    pfcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfcr_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .font_addr        (s_tdata[8:0]),
        .font_data        (s_tdata[16:9]),
        .char_code        (s_tdata[22:17]),
        .char_color       (s_tdata[25:23]),
        .first_of_message (s_tdata[26]),
        .cmd              (cmd),
        .status           (status),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_tlast          (m_tlast),
        .column_bits      (column_bits),
        .column_color     (column_color),
        .column_index     (column_index)
    );

    assign m_tdata = {3'b000, column_index, column_color, column_bits};

endmodule

// ----- hw/rtl/pfcr_checker.sv -----
module pfcr_checker
    import pfcr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // gap beat is blank and colourless
    a_gap_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[10:0] == 11'd0))
        else $error("gap beat carries column data");

    // a column beat always has its gap still to come, so input stays closed
    a_busy_on_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input open while a character is unfinished");

    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_RENDER) |=> !s_tready)
        else $error("character beat did not start rendering");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind proportional_font_column_renderer pfcr_checker u_pfcr_checker (.*);

// ----- sim/proportional_font_column_renderer_test.sv -----
module proportional_font_column_renderer_test;
    import pfcr_pkg::*;

    localparam int SETTLE_CYCLES  = 128;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0]  bits;
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] index;
        logic               last;
    } column_t;

    // typed: the expected beats are given in the row, not worked out
    typedef struct packed {
        logic               op;
        logic [FADDR_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] color;
        logic               first;
        logic               typed;
        logic [1:0]         n_typed;
        column_t            c0;
        column_t            c1;
    } item_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [BYTE_W-1:0]  font_mem [FONT_BYTES];
    logic [FADDR_W-1:0] col_addrs [$];
    logic [COUNT_W-1:0] col_count = '0;
    logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
    column_t            exp_cols [$];
    int                 errors       = 0;
    int                 quiet_cycles = 0;
    int                 stall_left   = 0;
    bit                 no_gaps      = 1'b0;

    proportional_font_column_renderer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        // [8:0] font_addr, [16:9] font_data, [22:17] char_code,
        // [25:23] char_color, [26] first_of_message
        .s_tdata     (s_tdata),
        // [0] op
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        // [7:0] column_bits, [10:8] column_color, [20:11] column_index
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic column_t column(input logic [7:0] bits, input logic [2:0] color,
                                       input logic [9:0] index, input logic last);
        column_t c;
        c.bits  = bits;
        c.color = color;
        c.index = index;
        c.last  = last;
        return c;
    endfunction

    function automatic item_t make_item(input logic op, input logic [8:0] addr,
                                        input logic [7:0] data, input logic [5:0] code,
                                        input logic [2:0] color, input logic first,
                                        input int n, input column_t c0, input column_t c1);
        item_t r;
        r.op      = op;
        r.addr    = addr;
        r.data    = data;
        r.code    = code;
        r.color   = color;
        r.first   = first;
        r.typed   = (n >= 0);
        r.n_typed = (n < 0) ? 2'd0 : 2'(n);
        r.c0      = c0;
        r.c1      = c1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies a font write, or walks the glyph widths and queues the column and gap beats of one character.
    function automatic void glyph_columns(input item_t r, input bit keep);
        logic [ADDR_W-1:0]  pos;
        logic [BYTE_W-1:0]  bits;
        logic [COLOR_W-1:0] clr;
        int                 glyph;
        int                 shown;
        if (r.op == OP_WRITE) begin
            font_mem[ADDR_W'(r.addr)] = r.data;
            return;
        end
        if (r.first)
            col_count = '0;
        glyph = (r.code != '0 && {1'b0, r.code} < cur_limit) ? int'(r.code) : 0;
        pos = '0;
        for (int i = 0; i < glyph; i++)
            pos = pos + ADDR_W'(font_mem[pos]) + ADDR_W'(1);
        if (font_mem[pos] == '0)
            return;
        shown = (font_mem[pos] > BYTE_W'(MAX_GLYPH_WIDTH)) ? MAX_GLYPH_WIDTH
                                                          : int'(font_mem[pos]);
        for (int i = 0; i <= shown; i++) begin
            if (i < shown) begin
                pos  = pos + ADDR_W'(1);
                bits = font_mem[pos];
                clr  = r.color;
            end else begin
                bits = '0;
                clr  = '0;
            end
            if (keep)
                exp_cols.push_back(column(bits, clr, col_count, i == shown));
            if (col_count < INDEX_CAP)
                col_count = col_count + COUNT_W'(1);
        end
    endfunction

    task automatic issue(input item_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {5'd0, r.first, r.color, r.code, r.data, r.addr};
        do @(posedge aclk); while (!s_tready);
        glyph_columns(r, !r.typed);
        if (r.typed && r.n_typed > 0)
            exp_cols.push_back(r.c0);
        if (r.typed && r.n_typed > 1)
            exp_cols.push_back(r.c1);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (exp_cols.size() != 0);
    endtask

    // zero-width glyphs give no beats, so the walk may still be running
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_limit = value;
    endtask

    // Lays out glyphs 0 to 7 back to back; only the columns that get shown are
    // written, and those addresses are the ones random writes may touch.
    task automatic load_font();
        int    widths [8];
        int    at;
        int    shown;
        item_t r;
        widths = '{2, 1, 0, MAX_GLYPH_WIDTH + 4, 3, 0, 2, 1};
        col_addrs.delete();
        at = 0;
        for (int g = 0; g < 8; g++) begin
            r       = '0;
            r.op    = OP_WRITE;
            r.addr  = FADDR_W'(at);
            r.data  = BYTE_W'(widths[g]);
            r.code  = CODE_W'($urandom);
            r.color = COLOR_W'($urandom);
            r.first = 1'($urandom);
            issue(r);
            shown = (widths[g] > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : widths[g];
            for (int c = 1; c <= shown; c++) begin
                r.addr = FADDR_W'(at + c);
                r.data = (g == 1) ? 8'hff : BYTE_W'($urandom);
                col_addrs.push_back(r.addr);
                issue(r);
            end
            at = at + widths[g] + 1;
        end
    endtask

    task automatic random_burst(input int count, input int write_pct, input int first_pct,
                                input int code_max);
        item_t r;
        for (int i = 0; i < count; i++) begin
            r       = '0;
            r.op    = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_RENDER;
            if (r.op == OP_WRITE)
                r.addr = col_addrs[$urandom_range(0, col_addrs.size() - 1)];
            else
                r.addr = FADDR_W'($urandom);
            r.data  = BYTE_W'($urandom);
            r.code  = CODE_W'($urandom_range(0, code_max));
            r.color = COLOR_W'($urandom);
            r.first = ($urandom_range(0, 99) < first_pct);
            if ($urandom_range(0, 29) == 0)
                hold_until_drained();
            issue(r);
        end
    endtask

    // the wide glyph 3 gives 17 beats per character
    task automatic long_message(input int count);
        for (int i = 0; i < count; i++)
            issue(make_item(OP_RENDER, 9'd0, 8'd0, 6'd3, COLOR_W'($urandom), 1'b0, -1,
                            '0, '0));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge aclk) begin
        column_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_cols.size() == 0) begin
                report_mismatch("beat with nothing pending", int'(m_tdata), 0);
            end else begin
                want = exp_cols.pop_front();
                if (m_tdata[7:0] !== want.bits)
                    report_mismatch("column_bits", int'(m_tdata[7:0]), int'(want.bits));
                if (m_tdata[10:8] !== want.color)
                    report_mismatch("column_color", int'(m_tdata[10:8]), int'(want.color));
                if (m_tdata[20:11] !== want.index)
                    report_mismatch("column_index", int'(m_tdata[20:11]), int'(want.index));
                if (m_tlast !== want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        item_t directed_items [$];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_font();

        // glyph 0 is two wide, glyph 1 one column of 8'hff at 4, glyph 2 empty,
        // glyph 3 wider than sixteen
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd1, 3'd7, 1'b1, 2,
            column(8'hff, 3'd7, 10'd0, 1'b0), column(8'h00, 3'd0, 10'd1, 1'b1)));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd2, 3'd5, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd1, 3'd0, 1'b0, 2,
            column(8'hff, 3'd0, 10'd2, 1'b0), column(8'h00, 3'd0, 10'd3, 1'b1)));
        directed_items.push_back(make_item(OP_RENDER, 9'd511, 8'hff, 6'd0, 3'd3, 1'b1, -1,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd3, 3'd4, 1'b0, -1,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd7, 3'd7, 1'b0, -1,
            '0, '0));
        directed_items.push_back(make_item(OP_WRITE, 9'd4, 8'h81, 6'd63, 3'd7, 1'b1, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd1, 3'd2, 1'b1, 2,
            column(8'h81, 3'd2, 10'd0, 1'b0), column(8'h00, 3'd0, 10'd1, 1'b1)));
        // empty glyph still restarts the index
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd2, 3'd6, 1'b1, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd1, 3'd5, 1'b0, 2,
            column(8'h81, 3'd5, 10'd0, 1'b0), column(8'h00, 3'd0, 10'd1, 1'b1)));
        // walk wraps past the top: glyph 2 sits at 511 and its column at 0
        directed_items.push_back(make_item(OP_WRITE, 9'd0, 8'd255, 6'd0, 3'd0, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_WRITE, 9'd256, 8'd254, 6'd0, 3'd0, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_WRITE, 9'd511, 8'd1, 6'd0, 3'd0, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd2, 3'd6, 1'b1, 2,
            column(8'hff, 3'd6, 10'd0, 1'b0), column(8'h00, 3'd0, 10'd1, 1'b1)));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd0, 3'd1, 1'b0, -1,
            '0, '0));
        directed_items.push_back(make_item(OP_WRITE, 9'd0, 8'd0, 6'd0, 3'd0, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd0, 3'd7, 1'b1, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_WRITE, 9'd0, 8'd2, 6'd0, 3'd0, 1'b0, 0,
            '0, '0));
        directed_items.push_back(make_item(OP_RENDER, 9'd0, 8'd0, 6'd5, 3'd0, 1'b0, -1,
            '0, '0));
        foreach (directed_items[i])
            issue(directed_items[i]);
        settle();

        set_limit(7'd1);
        random_burst(6, 25, 15, 63);
        settle();

        set_limit(7'd0);
        random_burst(4, 25, 15, 63);
        settle();

        // long message runs the index to its cap
        set_limit(LIMIT_RESET);
        issue(make_item(OP_RENDER, 9'd0, 8'd0, 6'd3, 3'd2, 1'b1, -1, '0, '0));
        no_gaps = 1'b1;
        long_message(30);
        no_gaps = 1'b0;
        long_message(31);
        settle();

        set_limit(7'd127);
        random_burst(6, 20, 12, 7);
        hold_until_drained();
        settle();

        set_limit(LIMIT_W'($urandom_range(2, 8)));
        random_burst(8, 20, 12, 63);
        settle();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
